// File: hw/rtl/cprdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cprdr_pkg
// Shared constants and types for the changed-pixel reblend block.
// ----------------------------------------------------------------------------
package cprdr_pkg;

    localparam int MAX_DIM     = 1024;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int DIM_CW      = DIM_W + 1;
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CH_W        = 8;
    localparam int RGB_W       = 3 * CH_W;
    localparam int MASK_W      = 16;
    localparam int NIB_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DIM_CW-1:0] WIDTH_RESET  = DIM_CW'(320);
    localparam logic [DIM_CW-1:0] HEIGHT_RESET = DIM_CW'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_CHANGED_MASK = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_PIXEL       = 1'b1
    } t_opcode;

    typedef struct packed {
        logic              hit;
        logic [DIM_W-1:0]  x;
        logic [DIM_W-1:0]  y;
        logic              done;
        logic              dvalid;
        logic [DIM_W-1:0]  left;
        logic [DIM_W-1:0]  top;
        logic [DIM_CW-1:0] right;
        logic [DIM_CW-1:0] bottom;
    } t_pix_info;

endpackage
`default_nettype wire

// File: hw/rtl/cprdr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cprdr_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module cprdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hw/rtl/cprdr_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cprdr_track
// Raster position counters, change flag and dirty rectangle tracking.
// ----------------------------------------------------------------------------
module cprdr_track
    import cprdr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic [IDX_W-1:0]  i_pixel_index,
    input  wire logic [DIM_CW-1:0] i_width,
    input  wire logic [DIM_CW-1:0] i_height,
    input  wire logic [MASK_W-1:0] i_mask,
    output t_pix_info              o_info
);

    logic [DIM_W-1:0] r_col, r_row, r_min_x, r_min_y, r_max_x, r_max_y;
    logic             r_any;
    logic [DIM_W-1:0] n_col, n_row, n_min_x, n_min_y, n_max_x, n_max_y;
    logic             n_any;

    logic [DIM_CW-1:0] w_cl, h_cl;
    logic [DIM_W-1:0]  w_m1, h_m1, x, y;
    logic              last_col, last_row, hit, done;
    logic [DIM_W-1:0]  u_min_x, u_min_y, u_max_x, u_max_y;
    logic              u_any;

    always_comb begin
        if (i_width == '0) begin
            w_cl = DIM_CW'(1);
        end else if (i_width > DIM_CW'(MAX_DIM)) begin
            w_cl = DIM_CW'(MAX_DIM);
        end else begin
            w_cl = i_width;
        end
        if (i_height == '0) begin
            h_cl = DIM_CW'(1);
        end else if (i_height > DIM_CW'(MAX_DIM)) begin
            h_cl = DIM_CW'(MAX_DIM);
        end else begin
            h_cl = i_height;
        end
        w_m1 = DIM_W'(w_cl - DIM_CW'(1));
        h_m1 = DIM_W'(h_cl - DIM_CW'(1));

        last_col = r_col >= w_m1;
        last_row = r_row >= h_m1;
        x        = last_col ? w_m1 : r_col;
        y        = last_row ? h_m1 : r_row;
        done     = last_col && last_row;

        hit = i_mask[i_pixel_index[IDX_W-1 -: NIB_W]] | i_mask[i_pixel_index[NIB_W-1:0]];

        u_min_x = r_min_x;
        u_min_y = r_min_y;
        u_max_x = r_max_x;
        u_max_y = r_max_y;
        u_any   = r_any;
        if (hit) begin
            u_any = 1'b1;
            if (!r_any) begin
                u_min_x = x;
                u_max_x = x;
                u_min_y = y;
                u_max_y = y;
            end else begin
                if (x < r_min_x) u_min_x = x;
                if (x > r_max_x) u_max_x = x;
                if (y < r_min_y) u_min_y = y;
                if (y > r_max_y) u_max_y = y;
            end
        end

        o_info.hit    = hit;
        o_info.x      = x;
        o_info.y      = y;
        o_info.done   = done;
        o_info.dvalid = done && u_any;
        o_info.left   = (done && u_any) ? u_min_x : '0;
        o_info.top    = (done && u_any) ? u_min_y : '0;
        o_info.right  = (done && u_any) ? ({1'b0, u_max_x} + DIM_CW'(1)) : '0;
        o_info.bottom = (done && u_any) ? ({1'b0, u_max_y} + DIM_CW'(1)) : '0;

        if (done) begin
            n_col   = '0;
            n_row   = '0;
            n_min_x = '0;
            n_min_y = '0;
            n_max_x = '0;
            n_max_y = '0;
            n_any   = 1'b0;
        end else begin
            n_min_x = u_min_x;
            n_min_y = u_min_y;
            n_max_x = u_max_x;
            n_max_y = u_max_y;
            n_any   = u_any;
            if (last_col) begin
                n_col = '0;
                n_row = y + DIM_W'(1);
            end else begin
                n_col = x + DIM_W'(1);
                n_row = y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
            r_any   <= 1'b0;
        end else if (i_adv) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_min_x <= n_min_x;
            r_min_y <= n_min_y;
            r_max_x <= n_max_x;
            r_max_y <= n_max_y;
            r_any   <= n_any;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/changed_pixel_reblend_dirty_rect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// changed_pixel_reblend_dirty_rect
// Rewrites pixels whose pair index names a changed base color and reports
// the dirty rectangle of each frame.
//
// Input channel (i_valid / o_stall): opcode 0 loads one color table entry
// and gives no result; opcode 1 presents the next raster pixel and gives
// exactly one result on the output channel (o_valid / i_stall).
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 frame
// width, 1 frame height, 2 changed mask; other indexes are ignored.
// Throughput: one request per cycle while o_stall is low, set by the single
// table read port and the position/rectangle update. An accepted pixel passes
// through the table read stage and then the output register.
// Reset clears position counters and rectangle tracking, loads width 320,
// height 200, mask 0. The color table is undefined until loaded.
// While the receiver stalls, the output register holds its result and one
// more pixel waits in the table read stage; then o_stall rises.
// On the last pixel of a frame frame_done rises, with the rectangle if any
// pixel was rewritten, and the counters wrap to the first pixel.
// ----------------------------------------------------------------------------
module changed_pixel_reblend_dirty_rect
    import cprdr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_opcode,
    input  wire logic [IDX_W-1:0]      i_table_index,
    input  wire logic [CH_W-1:0]       i_entry_red,
    input  wire logic [CH_W-1:0]       i_entry_green,
    input  wire logic [CH_W-1:0]       i_entry_blue,
    input  wire logic [IDX_W-1:0]      i_pixel_index,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_write_enable,
    output logic [DIM_W-1:0]           o_pixel_x,
    output logic [DIM_W-1:0]           o_pixel_y,
    output logic [CH_W-1:0]            o_out_red,
    output logic [CH_W-1:0]            o_out_green,
    output logic [CH_W-1:0]            o_out_blue,
    output logic                       o_frame_done,
    output logic                       o_dirty_valid,
    output logic [DIM_W-1:0]           o_dirty_left,
    output logic [DIM_W-1:0]           o_dirty_top,
    output logic [DIM_CW-1:0]          o_dirty_right,
    output logic [DIM_CW-1:0]          o_dirty_bottom,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DIM_CW-1:0] r_width, r_height;
    logic [MASK_W-1:0] r_mask;

    logic              r_s1_valid;
    t_pix_info         r_s1_info;
    logic              r_o_valid;
    t_pix_info         r_o_info;
    logic [RGB_W-1:0]  r_o_rgb;

    logic              s1_adv, acc, pix_acc, tw_acc;
    t_pix_info         info;
    logic [RGB_W-1:0]  ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_mask   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[DIM_CW-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[DIM_CW-1:0];
                CFG_CHANGED_MASK: r_mask   <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv  = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign acc     = i_valid && !o_stall;
    assign pix_acc = acc && (i_opcode == OP_PIXEL);
    assign tw_acc  = acc && (i_opcode == OP_TABLE_WRITE);

    cprdr_track u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (pix_acc),
        .i_pixel_index (i_pixel_index),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_mask        (r_mask),
        .o_info        (info)
    );

    cprdr_ram #(
        .WIDTH (RGB_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tw_acc),
        .i_waddr (i_table_index),
        .i_wdata ({i_entry_blue, i_entry_green, i_entry_red}),
        .i_re    (pix_acc),
        .i_raddr (i_pixel_index),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (pix_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_info <= info;
        end
        if (s1_adv) begin
            r_o_info <= r_s1_info;
            r_o_rgb  <= r_s1_info.hit ? ram_rdata : '0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_write_enable = r_o_info.hit;
    assign o_pixel_x      = r_o_info.x;
    assign o_pixel_y      = r_o_info.y;
    assign o_out_red      = r_o_rgb[CH_W-1:0];
    assign o_out_green    = r_o_rgb[2*CH_W-1:CH_W];
    assign o_out_blue     = r_o_rgb[RGB_W-1:2*CH_W];
    assign o_frame_done   = r_o_info.done;
    assign o_dirty_valid  = r_o_info.dvalid;
    assign o_dirty_left   = r_o_info.left;
    assign o_dirty_top    = r_o_info.top;
    assign o_dirty_right  = r_o_info.right;
    assign o_dirty_bottom = r_o_info.bottom;

    a_pix_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |=> r_s1_valid)
        else $error("accepted pixel did not enter the read stage");

    a_unhit_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |->
            (o_out_red == '0 && o_out_green == '0 && o_out_blue == '0))
        else $error("color present on a pixel that is not rewritten");

    a_dirty_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dirty_valid) |->
            (o_frame_done && o_dirty_right > {1'b0, o_dirty_left}
             && o_dirty_bottom > {1'b0, o_dirty_top}))
        else $error("malformed dirty rectangle");

    a_no_table_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tw_acc && !r_s1_valid) |=> !r_s1_valid)
        else $error("table write produced a result");

endmodule
`default_nettype wire
